@@ hdl/rsrk_pkg.sv @@
`default_nettype none

package rsrk_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned KEY3_W = 40;
  localparam int unsigned AGE_W  = 8;
  localparam int unsigned FILL_W = 5;

  // one stored record: 29-byte name in four words plus age
  typedef struct packed {
    logic [KEY_W-1:0]  key0;
    logic [KEY_W-1:0]  key1;
    logic [KEY_W-1:0]  key2;
    logic [KEY3_W-1:0] key3;
    logic [AGE_W-1:0]  age;
  } rec_t;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SRCH,
    ST_SHIFT
  } st_t;

endpackage

`default_nettype wire

@@ hdl/record_stack_with_remove_by_key_top.sv @@
`default_nettype none

// Bounded LIFO stack of name/age records with remove-by-name. A transaction
// is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with out_valid high. The receiver cannot stall,
// so out_* must be captured in that cycle. Push, clear, and pop or remove
// on an empty stack answer in the cycle after they are taken. Pop reads
// the top entry and answers from ST_POP; remove-by-name checks entries one
// at a time from the top (hit or miss), then moves each entry above the
// hit down one place, using the simple dual-port record memory: one read
// and one write each cycle. busy is high while a pop or a removal runs; a
// new transaction may be issued in the cycle its predecessor's result
// is shown. No clearing pass after reset: entries past the count go unused.
module record_stack_with_remove_by_key_top #(
  parameter int unsigned DEPTH = 16  // 2 .. 31; out_fill is 5 bits wide
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   in_action,
  input  wire logic [63:0]  in_key_word0,
  input  wire logic [63:0]  in_key_word1,
  input  wire logic [63:0]  in_key_word2,
  input  wire logic [39:0]  in_key_word3,
  input  wire logic [7:0]   in_age_in,
  output logic              out_valid,
  output logic              out_ok,
  output logic [63:0]       out_word0,
  output logic [63:0]       out_word1,
  output logic [63:0]       out_word2,
  output logic [39:0]       out_word3,
  output logic [7:0]        out_age_out,
  output logic [4:0]        out_fill
);
  import rsrk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  rec_t          in_rec;
  rec_t          res_rec;
  rec_t          mem_wdata;
  rec_t          mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  // pack the incoming record
  assign in_rec.key0 = in_key_word0;
  assign in_rec.key1 = in_key_word1;
  assign in_rec.key2 = in_key_word2;
  assign in_rec.key3 = in_key_word3;
  assign in_rec.age  = in_age_in;

  // sequencer: push/pop/search/shift, count and result registers
  rsrk_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_action (in_action),
    .in_rec    (in_rec),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_valid),
    .res_ok    (out_ok),
    .res_rec   (res_rec),
    .res_fill  (out_fill)
  );

  // record storage, one write and one registered read per cycle
  rsrk_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // removed record; zero on anything that removes nothing
  assign out_word0   = res_rec.key0;
  assign out_word1   = res_rec.key1;
  assign out_word2   = res_rec.key2;
  assign out_word3   = res_rec.key3;
  assign out_age_out = res_rec.age;

endmodule

`default_nettype wire

@@ hdl/rsrk_mem.sv @@
`default_nettype none

module rsrk_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire rsrk_pkg::rec_t               wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output rsrk_pkg::rec_t                    rd_data
);
  import rsrk_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/rsrk_ctrl.sv @@
`default_nettype none

module rsrk_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_action,
  input  wire rsrk_pkg::rec_t                       in_rec,
  output logic                                      mem_we,
  output logic [$clog2(DEPTH)-1:0]                  mem_waddr,
  output rsrk_pkg::rec_t                            mem_wdata,
  output logic [$clog2(DEPTH)-1:0]                  mem_raddr,
  input  wire rsrk_pkg::rec_t                       mem_rdata,
  output logic                                      res_valid,
  output logic                                      res_ok,
  output rsrk_pkg::rec_t                            res_rec,
  output logic [rsrk_pkg::FILL_W-1:0]               res_fill
);
  import rsrk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  st_t          state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  rec_t         req_r, req_nxt;
  rec_t         res_r, res_nxt;
  logic         ok_r, ok_nxt;
  logic         ov_r, ov_nxt;

  logic [CW-1:0]          cnt_m1;
  logic                   hit;
  logic [CW+FILL_W-1:0]   cnt_ext;
  act_t                   act;

  assign act     = act_t'(in_action);
  assign cnt_m1  = cnt_r - CW'(1);
  assign hit     = (mem_rdata.key0 == req_r.key0) && (mem_rdata.key1 == req_r.key1) &&
                   (mem_rdata.key2 == req_r.key2) && (mem_rdata.key3 == req_r.key3);
  assign cnt_ext = {{FILL_W{1'b0}}, cnt_r};

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = ov_r;
  assign res_ok    = ok_r;
  assign res_rec   = res_r;
  assign res_fill  = cnt_ext[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
    ok_r  <= ok_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    ok_nxt    = ok_r;
    ov_nxt    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_raddr = cnt_m1[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_rec;
          res_nxt = '0;
          ok_nxt  = 1'b0;
          case (act)
            ACT_PUSH: begin
              if (cnt_r < CW'(DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = in_rec;
                cnt_nxt   = cnt_r + CW'(1);
                ok_nxt    = 1'b1;
              end
              ov_nxt = 1'b1;
            end
            ACT_POP: begin
              if (cnt_r != '0) begin
                state_nxt = ST_POP;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r != '0) begin
                idx_nxt   = cnt_m1[AW-1:0];
                state_nxt = ST_SRCH;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
              ok_nxt  = 1'b1;
              ov_nxt  = 1'b1;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_POP: begin
        res_nxt   = mem_rdata;
        ok_nxt    = 1'b1;
        cnt_nxt   = cnt_m1;
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end

      // read data belongs to idx_r; one entry checked per cycle, top down
      ST_SRCH: begin
        if (hit) begin
          res_nxt = mem_rdata;
          ok_nxt  = 1'b1;
          if (CW'(idx_r) == cnt_m1) begin
            cnt_nxt   = cnt_m1;
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            mem_raddr = idx_r + AW'(1);
            state_nxt = ST_SHIFT;
          end
        end else if (idx_r == '0) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_raddr = idx_r - AW'(1);
          idx_nxt   = idx_r - AW'(1);
        end
      end

      // read data is entry idx_r+1; move it down while fetching the next
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (CW'(idx_r) + CW'(1) == cnt_m1) begin
          cnt_nxt   = cnt_m1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_raddr = idx_r + AW'(2);
          idx_nxt   = idx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
